// File: design/sha1_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 stream hasher package
// Shared constants, types and round helpers for controller and datapath.
// ---------------------------------------------------------------------------
package sha1_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 80;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    // byte source for the buffer write port
    typedef enum logic [1:0] {
        t_SRC_DATA = 2'd0,
        t_SRC_PAD  = 2'd1,
        t_SRC_ZERO = 2'd2,
        t_SRC_LEN  = 2'd3
    } t_src;

    // controller -> datapath
    typedef struct packed {
        logic       buf_we;      // write one byte into the block buffer
        logic [5:0] buf_addr;
        t_src       buf_src;
        logic [2:0] len_sel;     // which length byte, 0 = most significant
        logic       cnt_inc;     // advance byte count
        logic       cmp_start;   // begin compression of the buffer
        logic       out_load;    // load digest into output shift register
        logic       out_shift;   // move to next digest word
        logic       clear;       // return to initial state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       cmp_busy;
        logic [5:0] cnt_low;     // byte count modulo 64
    } t_status;

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        if (rnd < 7'd20) return 32'h5a827999;
        else if (rnd < 7'd40) return 32'h6ed9eba1;
        else if (rnd < 7'd60) return 32'h8f1bbcdc;
        else return 32'hca62c1d6;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (rnd < 7'd20) return (b & c) | (~b & d);
        else if (rnd >= 7'd40 && rnd < 7'd60) return (b & c) | (b & d) | (c & d);
        else return b ^ c ^ d;
    endfunction

endpackage

// File: design/sha1_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer, byte counter, one-round-per-cycle compression, digest output.
// ---------------------------------------------------------------------------
module sha1_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1_pkg::t_cmd    i_cmd,
    input  logic [7:0]        i_byte,
    output sha1_pkg::t_status o_status,
    output logic [31:0]       o_word
);

    // block buffer: 16 words of 4 bytes, written one byte a cycle while buf_we is set
    logic [31:0] r_buf [16];
    logic [63:0] r_cnt;
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [6:0]  r_rnd;
    logic        r_busy;
    logic [31:0] r_out [5];

    logic [63:0] bits;
    logic [7:0]  wr_byte;
    logic [31:0] w_new, w_cur, t_sum;
    logic [3:0]  widx;

    assign bits = {r_cnt[60:0], 3'b000};

    // byte to be written
    always_comb begin
        case (i_cmd.buf_src)
            sha1_pkg::t_SRC_DATA: wr_byte = i_byte;
            sha1_pkg::t_SRC_PAD:  wr_byte = sha1_pkg::PAD_BYTE;
            sha1_pkg::t_SRC_ZERO: wr_byte = 8'h00;
            sha1_pkg::t_SRC_LEN:  wr_byte = bits[8'(7 - i_cmd.len_sel) * 8 +: 8];
            default:              wr_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.buf_we) begin
            r_buf[i_cmd.buf_addr[5:2]][8'(3 - i_cmd.buf_addr[1:0]) * 8 +: 8] <= wr_byte;
        end
    end

    // message schedule held in a 16-word window
    assign widx  = r_rnd[3:0];
    assign w_new = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1
                 | (r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]) >> 31;
    assign w_cur = (r_rnd < 7'd16) ? r_w[widx] : w_new;
    assign t_sum = {r_a[26:0], r_a[31:27]} + sha1_pkg::round_f(r_rnd, r_b, r_c, r_d)
                 + r_e + w_cur + sha1_pkg::round_k(r_rnd);

    // compression rounds and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_busy <= 1'b0;
            r_rnd  <= '0;
            r_cnt  <= '0;
            r_h[0] <= sha1_pkg::H0; r_h[1] <= sha1_pkg::H1; r_h[2] <= sha1_pkg::H2;
            r_h[3] <= sha1_pkg::H3; r_h[4] <= sha1_pkg::H4;
        end else begin
            if (i_cmd.cnt_inc) r_cnt <= r_cnt + 64'd1;
            if (i_cmd.cmp_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
                for (int i = 0; i < 16; i++) r_w[i] <= r_buf[i];
            end else if (r_busy) begin
                r_e <= r_d;
                r_d <= r_c;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_b <= r_a;
                r_a <= t_sum;
                if (r_rnd >= 7'd16) begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= w_new;
                end
                if (r_rnd == 7'(sha1_pkg::ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_h[0] <= r_h[0] + t_sum;
                    r_h[1] <= r_h[1] + r_a;
                    r_h[2] <= r_h[2] + {r_b[1:0], r_b[31:2]};
                    r_h[3] <= r_h[3] + r_c;
                    r_h[4] <= r_h[4] + r_d;
                end
                r_rnd <= r_rnd + 7'd1;
            end
        end
    end

    // digest shift register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int i = 0; i < 5; i++) r_out[i] <= r_h[i];
        end else if (i_cmd.out_shift) begin
            for (int i = 0; i < 4; i++) r_out[i] <= r_out[i + 1];
            r_out[4] <= '0;
        end
    end

    assign o_word            = r_out[0];
    assign o_status.cmp_busy = r_busy;
    assign o_status.cnt_low  = r_cnt[5:0];

endmodule

// File: design/sha1_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 controller
// Input handshake, block sequencing, padding steps and digest emission.
// ---------------------------------------------------------------------------
module sha1_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_present,
    input  logic              i_end,
    input  sha1_pkg::t_status i_status,
    output sha1_pkg::t_cmd    o_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_index
);

    typedef enum logic [2:0] {
        S_IDLE, S_WAIT, S_PAD, S_FILL, S_LEN, S_FIN, S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_addr, n_addr;
    logic        r_end, n_end;
    logic        r_valid, n_valid;
    logic [2:0]  r_idx, n_idx;
    logic        r_go, n_go;       // compression pending start
    logic        acc;

    assign acc     = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_index = r_idx;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_end   = r_end;
        n_valid = r_valid;
        n_idx   = r_idx;
        n_go    = 1'b0;
        o_cmd   = '0;
        o_cmd.buf_addr = r_addr;
        o_cmd.buf_src  = sha1_pkg::t_SRC_DATA;
        o_cmd.cmp_start = r_go;
        case (r_state)
            S_IDLE: begin
                o_cmd.buf_addr = i_status.cnt_low;
                if (acc) begin
                    n_end = i_end;
                    if (i_present) begin
                        o_cmd.buf_we  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                        if (i_status.cnt_low == 6'd63) begin
                            n_go = 1'b1;
                            n_state = S_WAIT;
                        end else if (i_end) begin
                            n_addr  = i_status.cnt_low + 6'd1;
                            n_state = S_PAD;
                        end
                    end else if (i_end) begin
                        n_addr  = i_status.cnt_low;
                        n_state = S_PAD;
                    end
                end
            end
            S_WAIT: begin
                if (!r_go && !i_status.cmp_busy) begin
                    n_addr  = '0;
                    n_state = r_end ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                o_cmd.buf_we  = 1'b1;
                o_cmd.buf_src = sha1_pkg::t_SRC_PAD;
                n_addr = r_addr + 6'd1;
                if (r_addr == 6'd63) begin
                    n_go = 1'b1; n_state = S_FILL;   // length needs a second block
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                // zero up to the length field; wait first if a block is running
                if (r_go || i_status.cmp_busy) begin
                    n_state = S_FILL;
                end else if (r_addr == sha1_pkg::LEN_POS) begin
                    n_state = S_LEN;
                end else begin
                    o_cmd.buf_we  = 1'b1;
                    o_cmd.buf_src = sha1_pkg::t_SRC_ZERO;
                    n_addr = r_addr + 6'd1;
                    // pad byte past the length field: close this block first
                    if (r_addr == 6'd63) begin
                        n_go = 1'b1;
                    end
                end
            end
            S_LEN: begin
                o_cmd.buf_we  = 1'b1;
                o_cmd.buf_src = sha1_pkg::t_SRC_LEN;
                o_cmd.len_sel = r_addr[2:0];
                n_addr = r_addr + 6'd1;
                if (r_addr == 6'd63) begin
                    n_go = 1'b1; n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_go && !i_status.cmp_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_idx   = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (r_valid && i_ready) begin
                    o_cmd.out_shift = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd4) begin
                        n_valid = 1'b0;
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_end   <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_end   <= n_end;
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_go    <= n_go;
        end
    end

endmodule

// File: design/sha1_stream_hasher.sv
`timescale 1ns / 1ps
// A byte that completes a block holds the input until its 80 compression rounds,
//   one per cycle, are done; other bytes, unless they end the message, leave it ready.
// An end request runs padding (up to 72 buffer writes) and one or two blocks,
//   then five digest words leave one per accepted output request.
// Reset (i_rst_n low, synchronous) restores the SHA-1 initial values.
// ---------------------------------------------------------------------------
// SHA-1 stream hasher top level
// Byte stream in, five 32-bit digest words out per message.
// ---------------------------------------------------------------------------
module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);

    sha1_pkg::t_cmd    cmd;
    sha1_pkg::t_status status;
    logic [31:0]       word;
    logic [2:0]        idx;

    sha1_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_present (s_axis_tuser),
        .i_end     (s_axis_tlast),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_index   (idx)
    );

    sha1_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (s_axis_tdata),
        .o_status (status),
        .o_word   (word)
    );

    assign m_axis_tdata = {5'b0, idx, word};
    assign m_axis_tlast = (idx == 3'd4);

endmodule

// File: design/sha1_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 port checker
// Port-level properties of the hasher, attached by bind.
// ---------------------------------------------------------------------------
module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // no input taken while a digest is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");

    // tlast marks word four only
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd4)))
        else $error("tlast mismatch");

    // word index steps by one after each taken non-last word
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
        else $error("index step");

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output not held");

endmodule

bind sha1_stream_hasher sha1_checker u_sha1_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Drives byte streams with random gaps and output stalls, predicts each
// digest with a behavioural SHA-1 model and checks every output word.
// ---------------------------------------------------------------------------

// digest predictor and store of expected words
class sha1_digest_board;
    logic [31:0] chain[5];
    logic [7:0]  blk_buf[64];
    logic [63:0] byte_cnt;
    logic [39:0] exp_q[$];
    int          n_err;
    int          n_words;
    int          n_msgs;

    function new();
        n_err = 0;
        n_words = 0;
        n_msgs = 0;
        restart();
    endfunction

    function void restart();
        chain[0] = sha1_pkg::H0;
        chain[1] = sha1_pkg::H1;
        chain[2] = sha1_pkg::H2;
        chain[3] = sha1_pkg::H3;
        chain[4] = sha1_pkg::H4;
        byte_cnt = '0;
    endfunction

    static function logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function void compress(logic [7:0] b[64]);
        logic [31:0] w[80];
        logic [31:0] a, bb, c, d, e, f, t, k;
        for (int i = 0; i < 16; i++)
            w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain[0]; bb = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (bb & c) | (~bb & d);
                k = 32'h5a827999;
            end else if (i < 40) begin
                f = bb ^ c ^ d;
                k = 32'h6ed9eba1;
            end else if (i < 60) begin
                f = (bb & c) | (bb & d) | (c & d);
                k = 32'h8f1bbcdc;
            end else begin
                f = bb ^ c ^ d;
                k = 32'hca62c1d6;
            end
            t = rol(a, 5) + f + e + w[i] + k;
            e = d; d = c; c = rol(bb, 30); bb = a; a = t;
        end
        chain[0] += a; chain[1] += bb; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    // note one accepted input request
    function void note_request(logic [7:0] data, logic present, logic last);
        logic [7:0] pad[64];
        int          rem;
        logic [63:0] bits;
        if (present) begin
            blk_buf[byte_cnt[5:0]] = data;
            byte_cnt++;
            if (byte_cnt[5:0] == 0)
                compress(blk_buf);
        end
        if (!last)
            return;
        rem = byte_cnt[5:0];
        bits = byte_cnt << 3;
        for (int i = 0; i < 64; i++)
            pad[i] = (i < rem) ? blk_buf[i] : 8'h00;
        pad[rem] = sha1_pkg::PAD_BYTE;
        if (rem + 1 > 56) begin
            compress(pad);
            for (int i = 0; i < 64; i++)
                pad[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            pad[56 + i] = bits[63 - 8*i -: 8];
        compress(pad);
        for (int i = 0; i < 5; i++)
            exp_q.push_back({5'd0, 3'(i), chain[i]});
        n_msgs++;
        restart();
    endfunction

    // check one accepted digest word
    function void check_word(logic [39:0] data, logic last);
        logic [39:0] exp;
        if (exp_q.size() == 0) begin
            $error("unexpected digest word %h", data);
            n_err++;
            return;
        end
        exp = exp_q.pop_front();
        n_words++;
        if (data[31:0] !== exp[31:0]) begin
            $error("digest_word: expected %h, got %h", exp[31:0], data[31:0]);
            n_err++;
        end
        if (data[34:32] !== exp[34:32]) begin
            $error("word_index: expected %0d, got %0d", exp[34:32], data[34:32]);
            n_err++;
        end
        if (last !== (exp[34:32] == 3'd4)) begin
            $error("last_word: expected %b, got %b", exp[34:32] == 3'd4, last);
            n_err++;
        end
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] message_byte
    logic        s_axis_tuser = 1'b0; // [0] byte_present
    logic        s_axis_tlast = 1'b0; // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] digest_word, [34:32] word_index
    logic        m_axis_tlast;        // last_word

    sha1_digest_board board = new();
    int  cycles = 0;
    bit  hold_long = 1'b0;
    bit  stim_done = 1'b0;

    sha1_stream_hasher i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // timeout watch
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // input and output monitors
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata, m_axis_tlast);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, one long hold-off on request
    initial begin
        int g;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_long = 1'b0;
            end
            g = (stim_done || $urandom_range(0, 3) == 0) ? 0 : gap_len();
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // offer one request and wait for acceptance, with an optional gap first
    task automatic send_req(logic [7:0] data, logic present, logic last, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // a message of random bytes; tail picks how the end is marked
    task automatic send_msg(int len, bit gaps);
        bit bare_end;
        bare_end = (len == 0) || ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_req(8'($urandom), 1'b0, 1'b0, gaps); // idle noise
            send_req(8'($urandom), 1'b1, (i == len - 1) && !bare_end, gaps);
        end
        if (bare_end)
            send_req(8'($urandom), 1'b0, 1'b1, gaps);
    endtask

    initial begin
        int lens[$];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, byte extremes, padding boundaries
        send_req(8'h00, 1'b0, 1'b1, 1'b0);
        send_req(8'h00, 1'b0, 1'b0, 1'b0);
        send_req(8'hff, 1'b1, 1'b0, 1'b0);
        send_req(8'h00, 1'b1, 1'b0, 1'b0);
        send_req(8'h55, 1'b1, 1'b1, 1'b0);
        send_req(8'haa, 1'b1, 1'b1, 1'b0);
        lens = '{55, 56, 63, 64};
        foreach (lens[i])
            send_msg(lens[i], 1'b0);

        // back-pressure: long receiver hold-off while the sender keeps going
        hold_long = 1'b1;
        send_msg(3, 1'b0);
        send_msg(0, 1'b0);
        send_msg(70, 1'b0);

        // random short messages
        repeat (20) begin
            send_msg($urandom_range(0, 12), 1'b1);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (board.exp_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Covered %0d messages, %0d digest words checked, incl. empty,",
                 board.n_msgs, board.n_words);
        $display("block-boundary lengths, idle requests and a long output stall.");
        if (board.n_err == 0 && board.exp_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: files.f
design/sha1_pkg.sv
design/sha1_datapath.sv
design/sha1_ctrl.sv
design/sha1_stream_hasher.sv
design/sha1_checker.sv
tb/tb_top.sv
